FILE: src/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    localparam int NUM_DIGITS    = 4;
    localparam int NUM_CHARS     = 5;
    localparam int SEG_COUNT     = 7;
    // Data index of segment G for the first digit; each further digit sits 8 bits lower.
    localparam int DIGIT_G_BASE  = 49;
    localparam int DIGIT_STRIDE  = 8;
    localparam int FRAME_WIDTH   = 56;
    localparam int LEN_BITS      = 7;
    localparam int TIME_BITS     = 32;
    localparam int S_TDATA_BITS  = 96;
    localparam int M_TDATA_BITS  = 48;

    localparam logic [LEN_BITS-1:0] FRAME_MIN_BITS = 7'd56;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] SEP_RESET  = 8'h3A;

    localparam logic [2:0] REG_ACTIVE_LOW  = 3'd0;
    localparam logic [2:0] REG_INSERT_SEP  = 3'd1;
    localparam logic [2:0] REG_SEP_CHAR    = 3'd2;
    localparam logic [2:0] REG_TRIM        = 3'd3;
    localparam logic [2:0] REG_MIN_STABLE  = 3'd4;

    typedef struct packed {
        logic        segments_active_low;
        logic        insert_separator;
        logic [7:0]  separator_char;
        logic        trim_blanks;
        logic [31:0] min_stable_ms;
    } cfg_t;

    // chars[0] occupies the lowest byte, the length the top three bits.
    typedef struct packed {
        logic [2:0]           len;
        logic [4:0][7:0]      chars;
    } text_t;

    // Segment mask has A in bit 6 down to G in bit 0.
    function automatic logic [7:0] decode_segments(input logic [6:0] mask);
        logic [7:0] c;
        case (mask)
            7'h00: c = 8'h20;
            7'h7E: c = 8'h30;
            7'h30: c = 8'h31;
            7'h6D: c = 8'h32;
            7'h79: c = 8'h33;
            7'h33: c = 8'h34;
            7'h5B: c = 8'h35;
            7'h5F: c = 8'h36;
            7'h70: c = 8'h37;
            7'h7F: c = 8'h38;
            7'h7B: c = 8'h39;
            7'h77: c = 8'h41;
            7'h4E: c = 8'h43;
            7'h4F: c = 8'h45;
            7'h47: c = 8'h46;
            7'h37: c = 8'h48;
            7'h0E: c = 8'h4C;
            7'h67: c = 8'h50;
            7'h3E: c = 8'h55;
            7'h0D: c = 8'h63;
            7'h3D: c = 8'h64;
            7'h17: c = 8'h68;
            7'h10: c = 8'h69;
            7'h15: c = 8'h6E;
            7'h1D: c = 8'h6F;
            7'h05: c = 8'h72;
            7'h1C: c = 8'h75;
            default: c = CHAR_QMARK;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/ssd_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module ssd_lane import ssd_pkg::*; (
    input  wire logic [SEG_COUNT-1:0] seg_bits,
    input  wire logic                 active_low,
    output logic [7:0]                char_out,
    output logic                      numeric
);

    logic [SEG_COUNT-1:0] mask;

    assign mask     = seg_bits ^ {SEG_COUNT{active_low}};
    assign char_out = decode_segments(mask);
    assign numeric  = (char_out >= CHAR_ZERO) && (char_out <= CHAR_NINE);

endmodule

`default_nettype wire

FILE: src/ssd_text.sv
`timescale 1ns / 1ps
`default_nettype none

module ssd_text import ssd_pkg::*; (
    input  wire logic [NUM_DIGITS-1:0][7:0] digit_chars,
    input  wire logic [NUM_DIGITS-1:0]      digit_numeric,
    input  wire cfg_t                       cfg,
    output text_t                           text
);

    logic [4:0][7:0] buf_chars;
    logic [2:0]      buf_len;
    logic [2:0]      first;
    logic [2:0]      last;
    logic [2:0]      out_len;
    logic [3:0]      idx;
    logic            stop;

    always_comb begin
        buf_chars = {8'h00, digit_chars[3], digit_chars[2], digit_chars[1], digit_chars[0]};
        buf_len   = 3'd4;
        if (cfg.insert_separator && (&digit_numeric)) begin
            buf_chars = {digit_chars[3], digit_chars[2], cfg.separator_char,
                         digit_chars[1], digit_chars[0]};
            buf_len   = 3'd5;
        end

        first = 3'd0;
        last  = buf_len;
        stop  = 1'b0;
        if (cfg.trim_blanks) begin
            stop = 1'b0;
            for (int i = 0; i < NUM_CHARS; i++) begin
                if (!stop && (3'(i) < buf_len) && (buf_chars[i] == CHAR_SPACE)) begin
                    first = 3'(i + 1);
                end else begin
                    stop = 1'b1;
                end
            end
            // Walk back from the end; stop at the first non-blank or at the leading edge.
            stop = 1'b0;
            for (int i = NUM_CHARS - 1; i >= 0; i--) begin
                if (!stop && (3'(i) < buf_len)) begin
                    if ((3'(i) >= first) && (buf_chars[i] == CHAR_SPACE)) begin
                        last = 3'(i);
                    end else begin
                        stop = 1'b1;
                    end
                end
            end
        end
        out_len = last - first;

        text.len = out_len;
        for (int k = 0; k < NUM_CHARS; k++) begin
            idx = {1'b0, first} + 4'(k);
            if (3'(k) < out_len) begin
                text.chars[k] = buf_chars[idx[2:0]];
            end else begin
                text.chars[k] = 8'h00;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/ssd_filter.sv
`timescale 1ns / 1ps
`default_nettype none

module ssd_filter import ssd_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 st_valid,
    input  wire text_t                st_text,
    input  wire logic [TIME_BITS-1:0] st_now,
    input  wire logic [31:0]          min_stable_ms,
    output logic                      st_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output text_t                     out_text
);

    logic                 pending_valid_reg, pending_valid_next;
    text_t                pending_text_reg, pending_text_next;
    logic [TIME_BITS-1:0] pending_since_reg, pending_since_next;
    logic                 shown_valid_reg, shown_valid_next;
    text_t                shown_text_reg, shown_text_next;
    logic                 out_valid_reg, out_valid_next;
    text_t                out_text_reg, out_text_next;

    logic                 consume;
    logic                 changed;
    logic                 emit;
    logic [TIME_BITS-1:0] elapsed;

    assign st_ready  = !out_valid_reg || out_ready;
    assign consume   = st_valid && st_ready;
    assign out_valid = out_valid_reg;
    assign out_text  = out_text_reg;

    always_comb begin
        pending_valid_next = pending_valid_reg;
        pending_text_next  = pending_text_reg;
        pending_since_next = pending_since_reg;
        shown_valid_next   = shown_valid_reg;
        shown_text_next    = shown_text_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_text_next      = out_text_reg;
        changed            = !pending_valid_reg || (st_text != pending_text_reg);
        if (changed) begin
            elapsed = 32'd0;
        end else begin
            elapsed = st_now - pending_since_reg;
        end
        emit = !(shown_valid_reg && (st_text == shown_text_reg)) &&
               (elapsed >= min_stable_ms);
        if (consume) begin
            pending_valid_next = 1'b1;
            pending_text_next  = st_text;
            if (changed) begin
                pending_since_next = st_now;
            end
            if (emit) begin
                shown_valid_next = 1'b1;
                shown_text_next  = st_text;
                out_valid_next   = 1'b1;
                out_text_next    = st_text;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_valid_reg <= 1'b0;
            pending_text_reg  <= '0;
            pending_since_reg <= '0;
            shown_valid_reg   <= 1'b0;
            shown_text_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            pending_valid_reg <= pending_valid_next;
            pending_text_reg  <= pending_text_next;
            pending_since_reg <= pending_since_next;
            shown_valid_reg   <= shown_valid_next;
            shown_text_reg    <= shown_text_next;
            out_valid_reg     <= out_valid_next;
        end
        out_text_reg <= out_text_next;
    end

    a_emit_marks_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && emit) |=> (shown_valid_reg && (shown_text_reg == out_text_reg)))
        else $error("emitted text not recorded as shown");

    a_shown_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !pending_valid_reg |-> !shown_valid_reg)
        else $error("shown text without a pending text");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_text_reg.len <= 3'd5))
        else $error("text length out of range");

    a_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && shown_valid_reg && (st_text == shown_text_reg)) |=>
            (!out_valid_reg || $stable(out_text_reg)))
        else $error("same text emitted twice");

endmodule

`default_nettype wire

FILE: src/seven_segment_display_text_decoder.sv
// An accepted frame is held in the input register, then, if the filter emits it, in the output register on m_tdata.
// Throughput: one frame per cycle; the filter stage accepts a beat whenever the output
// register is empty or being taken in the same cycle.
// Frames shorter than 56 bits are dropped at the input register and give no result.
// Reset (aresetn low, synchronous) clears the filter history and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_display_text_decoder import ssd_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // frame_data [55:0], frame_length [62:56], now_ms [94:63], zero [95]
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // char_0 [7:0], char_1 [15:8], char_2 [23:16], char_3 [31:24], char_4 [39:32],
    // text_length [42:40], zero [47:43]
    output logic [M_TDATA_BITS-1:0]      m_tdata,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [4:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    cfg_t                     cfg_reg, cfg_next;
    logic [FRAME_WIDTH-1:0]   frame_data;
    logic [LEN_BITS-1:0]      frame_length;
    logic [TIME_BITS-1:0]     now_ms;
    logic [NUM_DIGITS-1:0][7:0] digit_chars;
    logic [NUM_DIGITS-1:0]    digit_numeric;
    text_t                    text;
    logic                     st_valid_reg, st_valid_next;
    text_t                    st_text_reg;
    logic [TIME_BITS-1:0]     st_now_reg;
    logic                     st_ready;
    logic                     s_accept;
    logic                     cfg_write;
    text_t                    out_text;

    assign frame_data   = s_tdata[FRAME_WIDTH-1:0];
    assign frame_length = s_tdata[FRAME_WIDTH+LEN_BITS-1:FRAME_WIDTH];
    assign now_ms       = s_tdata[FRAME_WIDTH+LEN_BITS+TIME_BITS-1:FRAME_WIDTH+LEN_BITS];

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (paddr[4:2])
                REG_ACTIVE_LOW: cfg_next.segments_active_low = pwdata[0];
                REG_INSERT_SEP: cfg_next.insert_separator    = pwdata[0];
                REG_SEP_CHAR:   cfg_next.separator_char      = pwdata[7:0];
                REG_TRIM:       cfg_next.trim_blanks         = pwdata[0];
                REG_MIN_STABLE: cfg_next.min_stable_ms       = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ACTIVE_LOW: prdata = {31'd0, cfg_reg.segments_active_low};
            REG_INSERT_SEP: prdata = {31'd0, cfg_reg.insert_separator};
            REG_SEP_CHAR:   prdata = {24'd0, cfg_reg.separator_char};
            REG_TRIM:       prdata = {31'd0, cfg_reg.trim_blanks};
            REG_MIN_STABLE: prdata = cfg_reg.min_stable_ms;
            default:        prdata = 32'd0;
        endcase
    end

    // One decode lane per digit
    for (genvar l = 0; l < NUM_DIGITS; l++) begin : g_lane
        localparam int G_INDEX = DIGIT_G_BASE - DIGIT_STRIDE * l;
        ssd_lane u_lane (
            .seg_bits   (frame_data[G_INDEX +: SEG_COUNT]),
            .active_low (cfg_reg.segments_active_low),
            .char_out   (digit_chars[l]),
            .numeric    (digit_numeric[l])
        );
    end

    ssd_text u_text (
        .digit_chars   (digit_chars),
        .digit_numeric (digit_numeric),
        .cfg           (cfg_reg),
        .text          (text)
    );

    // Input register: holds the assembled text of the last accepted frame; only a full-length frame marks it valid.
    assign s_tready = !st_valid_reg || st_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        st_valid_next = st_valid_reg && !st_ready;
        if (s_accept) begin
            st_valid_next = (frame_length >= FRAME_MIN_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.segments_active_low <= 1'b0;
            cfg_reg.insert_separator    <= 1'b0;
            cfg_reg.separator_char      <= SEP_RESET;
            cfg_reg.trim_blanks         <= 1'b0;
            cfg_reg.min_stable_ms       <= 32'd0;
            st_valid_reg                <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            st_valid_reg <= st_valid_next;
        end
        if (s_accept) begin
            st_text_reg <= text;
            st_now_reg  <= now_ms;
        end
    end

    ssd_filter u_filter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .st_valid      (st_valid_reg),
        .st_text       (st_text_reg),
        .st_now        (st_now_reg),
        .min_stable_ms (cfg_reg.min_stable_ms),
        .st_ready      (st_ready),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_text      (out_text)
    );

    assign m_tdata = {5'd0, out_text};

endmodule

`default_nettype wire
